[rtl/julia_escape_time_pixel_top_defines.svh]
// assertion macros for the julia escape time pixel block
`ifndef JULIA_ESCAPE_TIME_PIXEL_TOP_DEFINES_SVH
`define JULIA_ESCAPE_TIME_PIXEL_TOP_DEFINES_SVH

// same-cycle implication
`define JET_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("jet assertion failed");

// next-cycle implication
`define JET_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("jet assertion failed");

`endif

[rtl/jet_pkg.sv]
// shared constants and types of the julia escape time pixel block
package jet_pkg;

   localparam int MAX_DIM   = 4096;
   localparam int FRAC_BITS = 28;

   localparam int DIM_W  = 13;
   localparam int PIX_W  = 12;
   localparam int C_W    = 31;
   localparam int LIM_W  = 16;
   localparam int GRAY_W = 8;

   localparam int DIM_CAP = (MAX_DIM > (2**DIM_W - 1)) ? (2**DIM_W - 1) : MAX_DIM;

   localparam int Z_W    = 32;
   localparam int PROD_W = 64;
   localparam int NUM_W  = PIX_W + FRAC_BITS + 1;
   localparam int CNT_W  = $clog2(NUM_W);

   localparam int ADDR_W = 5;
   localparam int DATA_W = 32;
   localparam int IDX_W  = ADDR_W - 2;

   localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH     = 3'd0;
   localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT    = 3'd1;
   localparam logic [IDX_W-1:0] REG_C_REAL          = 3'd2;
   localparam logic [IDX_W-1:0] REG_C_IMAG          = 3'd3;
   localparam logic [IDX_W-1:0] REG_ITERATION_LIMIT = 3'd4;

   typedef struct packed {
      logic [DIM_W-1:0]        image_width;
      logic [DIM_W-1:0]        image_height;
      logic signed [C_W-1:0]   c_real;
      logic signed [C_W-1:0]   c_imag;
      logic [LIM_W-1:0]        iteration_limit;
   } cfg_type;

   typedef struct packed {
      logic load_pixel;
      logic map_step;
      logic map_done;
      logic mul;
      logic update;
      logic finish;
      logic gray_step;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic escaped;
      logic at_limit;
   } status_type;

endpackage

[rtl/julia_escape_time_pixel_top.sv]
// top level of the julia escape time pixel block
// a pixel passes the coordinate dividers, the multiply/test loop once per z update,
// the gray divider and then the output register; a new pixel is taken only in idle,
// after the previous result has been loaded into the output register
// a finished result waits in the output register while the next pixel is taken
// reset: synchronous, registers to defaults, controller idle, no result pending
`include "julia_escape_time_pixel_top_defines.svh"

module julia_escape_time_pixel_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [jet_pkg::PIX_W-1:0]   req_pixel_x,
   input  logic [jet_pkg::PIX_W-1:0]   req_pixel_y,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [jet_pkg::GRAY_W-1:0]  rsp_gray_level,
   output logic [jet_pkg::LIM_W-1:0]   rsp_iterations,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [jet_pkg::ADDR_W-1:0]  paddr,
   input  logic [jet_pkg::DATA_W-1:0]  pwdata,
   output logic [jet_pkg::DATA_W-1:0]  prdata,
   output logic                        pready
);
   import jet_pkg::*;

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   jet_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   jet_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   jet_dpath u_dpath (
      .clock          (clock),
      .cfg            (cfg),
      .cmd            (cmd),
      .status         (status),
      .req_pixel_x    (req_pixel_x),
      .req_pixel_y    (req_pixel_y),
      .rsp_gray_level (rsp_gray_level),
      .rsp_iterations (rsp_iterations)
   );

   `JET_ASSERT_IMPLY(a_iter_bound, clock, reset, rsp_valid, rsp_iterations <= cfg.iteration_limit)
   `JET_ASSERT_NEXT(a_busy_after_transfer, clock, reset, req_valid && !req_stall, req_stall)
   `JET_ASSERT_IMPLY(a_gray_full, clock, reset, rsp_valid && (cfg.iteration_limit != '0) && (rsp_iterations == cfg.iteration_limit), rsp_gray_level == 8'hFF)

endmodule

[rtl/jet_csr.sv]
// configuration registers behind the apb-style port
module jet_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [jet_pkg::ADDR_W-1:0]  paddr,
   input  logic [jet_pkg::DATA_W-1:0]  pwdata,
   output logic [jet_pkg::DATA_W-1:0]  prdata,
   output logic                        pready,
   output jet_pkg::cfg_type            cfg
);
   import jet_pkg::*;

   localparam logic [DIM_W-1:0] RESET_DIM   = 13'd1024;
   localparam logic [LIM_W-1:0] RESET_LIMIT = 16'd256;

   logic [DIM_W-1:0]      width_ff, width_in;
   logic [DIM_W-1:0]      height_ff, height_in;
   logic signed [C_W-1:0] c_real_ff, c_real_in;
   logic signed [C_W-1:0] c_imag_ff, c_imag_in;
   logic [LIM_W-1:0]      limit_ff, limit_in;
   logic                  wr;
   logic [IDX_W-1:0]      idx;

   assign pready = 1'b1;
   assign wr     = psel & penable & pwrite;
   assign idx    = paddr[ADDR_W-1:2];

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      c_real_in = c_real_ff;
      c_imag_in = c_imag_ff;
      limit_in  = limit_ff;
      if (wr) begin
         case (idx)
            REG_IMAGE_WIDTH: begin
               width_in = pwdata[DIM_W-1:0];
            end
            REG_IMAGE_HEIGHT: begin
               height_in = pwdata[DIM_W-1:0];
            end
            REG_C_REAL: begin
               c_real_in = pwdata[C_W-1:0];
            end
            REG_C_IMAG: begin
               c_imag_in = pwdata[C_W-1:0];
            end
            REG_ITERATION_LIMIT: begin
               limit_in = pwdata[LIM_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RESET_DIM;
         height_ff <= RESET_DIM;
         c_real_ff <= '0;
         c_imag_ff <= '0;
         limit_ff  <= RESET_LIMIT;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         c_real_ff <= c_real_in;
         c_imag_ff <= c_imag_in;
         limit_ff  <= limit_in;
      end
   end

   always_comb begin
      case (idx)
         REG_IMAGE_WIDTH: begin
            prdata = DATA_W'(width_ff);
         end
         REG_IMAGE_HEIGHT: begin
            prdata = DATA_W'(height_ff);
         end
         REG_C_REAL: begin
            prdata = DATA_W'(c_real_ff);
         end
         REG_C_IMAG: begin
            prdata = DATA_W'(c_imag_ff);
         end
         REG_ITERATION_LIMIT: begin
            prdata = DATA_W'(limit_ff);
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   assign cfg.image_width     = width_ff;
   assign cfg.image_height    = height_ff;
   assign cfg.c_real          = c_real_ff;
   assign cfg.c_imag          = c_imag_ff;
   assign cfg.iteration_limit = limit_ff;

endmodule

[rtl/jet_ctrl.sv]
// controller state machine sequencing mapping, iteration and gray scaling
module jet_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output jet_pkg::cmd_type     cmd,
   input  jet_pkg::status_type  status
);
   import jet_pkg::*;

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_MAP      = 3'd1;
   localparam logic [2:0] ST_MAP_DONE = 3'd2;
   localparam logic [2:0] ST_MUL      = 3'd3;
   localparam logic [2:0] ST_TEST     = 3'd4;
   localparam logic [2:0] ST_GRAY     = 3'd5;
   localparam logic [2:0] ST_DONE     = 3'd6;

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_pixel = 1'b1;
               cnt_in         = '0;
               state_in       = ST_MAP;
            end
         end
         ST_MAP: begin
            cmd.map_step = 1'b1;
            cnt_in       = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(NUM_W - 1)) begin
               state_in = ST_MAP_DONE;
            end
         end
         ST_MAP_DONE: begin
            cmd.map_done = 1'b1;
            state_in     = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_TEST;
         end
         ST_TEST: begin
            if (status.escaped || status.at_limit) begin
               cmd.finish = 1'b1;
               cnt_in     = '0;
               state_in   = ST_GRAY;
            end else begin
               cmd.update = 1'b1;
               state_in   = ST_MUL;
            end
         end
         ST_GRAY: begin
            cmd.gray_step = 1'b1;
            cnt_in        = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(GRAY_W - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

[rtl/jet_dpath.sv]
// datapath: coordinate dividers, complex square step, gray divider, result register
module jet_dpath (
   input  logic                        clock,
   input  jet_pkg::cfg_type            cfg,
   input  jet_pkg::cmd_type            cmd,
   output jet_pkg::status_type         status,
   input  logic [jet_pkg::PIX_W-1:0]   req_pixel_x,
   input  logic [jet_pkg::PIX_W-1:0]   req_pixel_y,
   output logic [jet_pkg::GRAY_W-1:0]  rsp_gray_level,
   output logic [jet_pkg::LIM_W-1:0]   rsp_iterations
);
   import jet_pkg::*;

   localparam int HALF_W = DIM_W - 1;
   localparam int GNUM_W = LIM_W + GRAY_W;

   localparam logic [PROD_W-1:0]        BOUND  = PROD_W'(4) << (2 * FRAC_BITS);
   localparam logic [PROD_W-1:0]        Q_POS  = 64'h0000_0000_7FFF_FFFF;
   localparam logic [PROD_W-1:0]        Q_NEG  = 64'h0000_0000_8000_0000;
   localparam logic signed [PROD_W-1:0] S_HI   = 64'sh0000_0000_7FFF_FFFF;
   localparam logic signed [PROD_W-1:0] S_LO   = -64'sh0000_0000_8000_0000;
   localparam logic signed [Z_W-1:0]    Z_MAX  = 32'sh7FFF_FFFF;
   localparam logic signed [Z_W-1:0]    Z_MIN  = 32'sh8000_0000;

   function automatic logic signed [Z_W-1:0] sat_map(input logic neg,
                                                     input logic [NUM_W-1:0] q);
      logic [PROD_W-1:0] q64;
      logic [PROD_W-1:0] nq;
      q64 = PROD_W'(q);
      nq  = -q64;
      if (!neg) begin
         return (q64 > Q_POS) ? Z_MAX : q64[Z_W-1:0];
      end
      return (q64 > Q_NEG) ? Z_MIN : nq[Z_W-1:0];
   endfunction

   function automatic logic signed [Z_W-1:0] sat_z(input logic signed [PROD_W-1:0] v);
      if (v > S_HI) begin
         return Z_MAX;
      end
      if (v < S_LO) begin
         return Z_MIN;
      end
      return v[Z_W-1:0];
   endfunction

   logic [DIM_W-1:0]      w_cl, h_cl;
   logic [HALF_W-1:0]     half [2];
   logic [HALF_W-1:0]     side_raw, side;
   logic [PIX_W-1:0]      pos [2];
   logic signed [PIX_W:0] diff [2];
   logic signed [PIX_W:0] ndiff [2];
   logic [PIX_W-1:0]      mag [2];
   logic [HALF_W:0]       shifted [2];
   logic [HALF_W:0]       reduced [2];
   logic                  q_bit [2];

   logic [NUM_W-1:0]      num_ff [2];
   logic [NUM_W-1:0]      num_in [2];
   logic [HALF_W-1:0]     rem_ff [2];
   logic [HALF_W-1:0]     rem_in [2];
   logic                  neg_ff [2];
   logic                  neg_in [2];

   logic signed [Z_W-1:0]    zr_ff, zr_in, zi_ff, zi_in;
   logic signed [PROD_W-1:0] rr_ff, rr_in, ii_ff, ii_in, ri_ff, ri_in;
   logic signed [PROD_W-1:0] re_diff, re_sh, im_sh, re_sum, im_sum;
   logic [PROD_W-1:0]        mag2;
   logic [LIM_W-1:0]         steps_ff, steps_in;
   logic [LIM_W-1:0]         count_ff, count_in, fin_count;
   logic                     escaped;

   logic [GNUM_W-1:0]   gnum_ff, gnum_in;
   logic [GNUM_W-2:0]   gden_ff, gden_in;
   logic [GRAY_W-1:0]   gq_ff, gq_in;
   logic                g_ge;
   logic [GRAY_W-1:0]   out_gray_ff, out_gray_in;
   logic [LIM_W-1:0]    out_iter_ff, out_iter_in;

   // side length of the half image, clamped to the supported size
   assign w_cl     = (cfg.image_width > DIM_W'(DIM_CAP)) ? DIM_W'(DIM_CAP) : cfg.image_width;
   assign h_cl     = (cfg.image_height > DIM_W'(DIM_CAP)) ? DIM_W'(DIM_CAP) : cfg.image_height;
   assign half[0]  = w_cl[DIM_W-1:1];
   assign half[1]  = h_cl[DIM_W-1:1];
   assign side_raw = (half[0] > half[1]) ? half[0] : half[1];
   assign side     = (side_raw == '0) ? HALF_W'(1) : side_raw;
   assign pos[0]   = req_pixel_x;
   assign pos[1]   = req_pixel_y;

   // restoring dividers, one quotient bit per cycle in each lane
   always_comb begin
      for (int k = 0; k < 2; k++) begin
         diff[k]    = $signed({1'b0, pos[k]}) - $signed({1'b0, half[k]});
         ndiff[k]   = -diff[k];
         mag[k]     = diff[k][PIX_W] ? ndiff[k][PIX_W-1:0] : diff[k][PIX_W-1:0];
         shifted[k] = {rem_ff[k], num_ff[k][NUM_W-1]};
         reduced[k] = shifted[k] - {1'b0, side};
         q_bit[k]   = (shifted[k] >= {1'b0, side});
         num_in[k]  = num_ff[k];
         rem_in[k]  = rem_ff[k];
         neg_in[k]  = neg_ff[k];
         if (cmd.load_pixel) begin
            num_in[k] = NUM_W'({mag[k], {(FRAC_BITS + 1){1'b0}}});
            rem_in[k] = '0;
            neg_in[k] = diff[k][PIX_W];
         end else if (cmd.map_step) begin
            num_in[k] = {num_ff[k][NUM_W-2:0], q_bit[k]};
            rem_in[k] = q_bit[k] ? reduced[k][HALF_W-1:0] : shifted[k][HALF_W-1:0];
         end
      end
   end

   // complex square step and escape test
   assign re_diff   = rr_ff - ii_ff;
   assign re_sh     = re_diff >>> FRAC_BITS;
   assign im_sh     = ri_ff >>> (FRAC_BITS - 1);
   assign re_sum    = re_sh + PROD_W'(cfg.c_real);
   assign im_sum    = im_sh + PROD_W'(cfg.c_imag);
   assign mag2      = $unsigned(rr_ff) + $unsigned(ii_ff);
   assign escaped   = (steps_ff != '0) && (mag2 > BOUND);
   assign fin_count = escaped ? (steps_ff - LIM_W'(1)) : steps_ff;

   assign status.escaped  = escaped;
   assign status.at_limit = (steps_ff == cfg.iteration_limit);

   always_comb begin
      zr_in    = zr_ff;
      zi_in    = zi_ff;
      rr_in    = rr_ff;
      ii_in    = ii_ff;
      ri_in    = ri_ff;
      steps_in = steps_ff;
      count_in = count_ff;
      if (cmd.load_pixel) begin
         steps_in = '0;
      end
      if (cmd.map_done) begin
         zr_in = sat_map(neg_ff[0], num_ff[0]);
         zi_in = sat_map(neg_ff[1], num_ff[1]);
      end
      if (cmd.mul) begin
         rr_in = zr_ff * zr_ff;
         ii_in = zi_ff * zi_ff;
         ri_in = zr_ff * zi_ff;
      end
      if (cmd.update) begin
         zr_in    = sat_z(re_sum);
         zi_in    = sat_z(im_sum);
         steps_in = steps_ff + LIM_W'(1);
      end
      if (cmd.finish) begin
         count_in = fin_count;
      end
   end

   // gray level divider: count * 255 / limit, one bit per cycle
   assign g_ge = (gnum_ff >= {1'b0, gden_ff});

   always_comb begin
      gnum_in     = gnum_ff;
      gden_in     = gden_ff;
      gq_in       = gq_ff;
      out_gray_in = out_gray_ff;
      out_iter_in = out_iter_ff;
      if (cmd.finish) begin
         gnum_in = {fin_count, GRAY_W'(0)} - GNUM_W'(fin_count);
         gden_in = {cfg.iteration_limit, (GRAY_W - 1)'(0)};
         gq_in   = '0;
      end else if (cmd.gray_step) begin
         gnum_in = g_ge ? (gnum_ff - {1'b0, gden_ff}) : gnum_ff;
         gden_in = gden_ff >> 1;
         gq_in   = {gq_ff[GRAY_W-2:0], g_ge};
      end
      if (cmd.load_out) begin
         out_gray_in = (cfg.iteration_limit == '0) ? '0 : gq_ff;
         out_iter_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 2; k++) begin
         num_ff[k] <= num_in[k];
         rem_ff[k] <= rem_in[k];
         neg_ff[k] <= neg_in[k];
      end
      zr_ff       <= zr_in;
      zi_ff       <= zi_in;
      rr_ff       <= rr_in;
      ii_ff       <= ii_in;
      ri_ff       <= ri_in;
      steps_ff    <= steps_in;
      count_ff    <= count_in;
      gnum_ff     <= gnum_in;
      gden_ff     <= gden_in;
      gq_ff       <= gq_in;
      out_gray_ff <= out_gray_in;
      out_iter_ff <= out_iter_in;
   end

   assign rsp_gray_level = out_gray_ff;
   assign rsp_iterations = out_iter_ff;

endmodule

[test/tb.sv]
// testbench for the julia escape time pixel block: predicted escape counts and gray levels, register readback
`timescale 1ns / 1ps

module tb;
   import jet_pkg::*;

   localparam int RUN_LIMIT = 4_000_000;
   localparam int PHASES = 10;
   localparam int PHASE_PIXELS = 88;

   typedef struct packed {
      logic [GRAY_W-1:0] gray;
      logic [LIM_W-1:0]  iterations;
   } escape_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [PIX_W-1:0]    req_pixel_x = '0;
   logic [PIX_W-1:0]    req_pixel_y = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [GRAY_W-1:0]   rsp_gray_level;
   logic [LIM_W-1:0]    rsp_iterations;
   logic                psel = 1'b0;
   logic                penable = 1'b0;
   logic                pwrite = 1'b0;
   logic [ADDR_W-1:0]   paddr = '0;
   logic [DATA_W-1:0]   pwdata = '0;
   logic [DATA_W-1:0]   prdata;
   logic                pready;

   cfg_type     cfg_model = '{image_width: 1024, image_height: 1024, c_real: 0, c_imag: 0,
                              iteration_limit: 256};
   escape_type  pending_escapes[$];
   bit          send_gaps = 1'b1;
   bit          stall_gaps = 1'b1;
   int unsigned hold_cycles = 0;
   int unsigned cycle_count = 0;
   int unsigned mismatches = 0;
   int unsigned pixels_sent = 0;
   int unsigned results_checked = 0;
   int unsigned csr_writes = 0;

   julia_escape_time_pixel_top dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_pixel_x    (req_pixel_x),
      .req_pixel_y    (req_pixel_y),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_gray_level (rsp_gray_level),
      .rsp_iterations (rsp_iterations),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= RUN_LIMIT) begin
         $display("timeout with %0d results outstanding", pending_escapes.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      if (mismatches < 40)
         $display("mismatch at cycle %0d: %s got %0d want %0d", cycle_count, what, got, want);
      mismatches++;
   endtask

   function automatic longint signed clamp_z(input longint signed v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint signed to_plane(input logic [PIX_W-1:0] pos,
                                               input longint signed half,
                                               input longint signed side);
      longint signed offset;
      offset = longint'(pos) - half;
      return clamp_z((offset * (longint'(1) << (FRAC_BITS + 1))) / side);
   endfunction

   function automatic escape_type predict_escape(input logic [PIX_W-1:0] px,
                                                 input logic [PIX_W-1:0] py);
      longint signed half_w, half_h, side, zr, zi, rr, ii, ri, cr, ci;
      longint unsigned mag, bound;
      int unsigned steps, w, h, gray_full;
      escape_type r;
      w = (int'(cfg_model.image_width) > MAX_DIM) ? MAX_DIM : int'(cfg_model.image_width);
      h = (int'(cfg_model.image_height) > MAX_DIM) ? MAX_DIM : int'(cfg_model.image_height);
      half_w = w >> 1;
      half_h = h >> 1;
      side = (half_w > half_h) ? half_w : half_h;
      if (side == 0) side = 1;
      zr = to_plane(px, half_w, side);
      zi = to_plane(py, half_h, side);
      cr = cfg_model.c_real;
      ci = cfg_model.c_imag;
      bound = 64'd4 << (2 * FRAC_BITS);
      for (steps = 0; steps < cfg_model.iteration_limit; steps++) begin
         rr = zr * zr;
         ii = zi * zi;
         ri = zr * zi;
         zr = clamp_z(((rr - ii) >>> FRAC_BITS) + cr);
         zi = clamp_z((ri >>> (FRAC_BITS - 1)) + ci);
         mag = $unsigned(zr * zr) + $unsigned(zi * zi);
         if (mag > bound) break;
      end
      gray_full = (cfg_model.iteration_limit == 0) ? 0
                : (steps * 255) / cfg_model.iteration_limit;
      r.gray = gray_full[GRAY_W-1:0];
      r.iterations = steps[LIM_W-1:0];
      return r;
   endfunction

   // result stall control, also serves long hold-offs
   initial begin : result_stall_ctl
      int unsigned wait_left;
      wait_left = 0;
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            wait_left = hold_cycles;
            hold_cycles = 0;
         end else if (rsp_valid && !rsp_stall) begin
            wait_left = stall_gaps ? $urandom_range(0, 19) : 0;
         end
         if (wait_left > 0) begin
            rsp_stall <= 1'b1;
            wait_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : check_results
      escape_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_escapes.size() == 0) begin
            report_mismatch("result with nothing pending, iterations", rsp_iterations, 0);
         end else begin
            want = pending_escapes.pop_front();
            if (rsp_iterations !== want.iterations)
               report_mismatch("iterations", rsp_iterations, want.iterations);
            if (rsp_gray_level !== want.gray)
               report_mismatch("gray_level", rsp_gray_level, want.gray);
            results_checked++;
         end
      end
   end

   task automatic send_pixel(input logic [PIX_W-1:0] px, input logic [PIX_W-1:0] py);
      int unsigned gap;
      gap = send_gaps ? $urandom_range(0, 19) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_pixel_x <= px;
      req_pixel_y <= py;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_escapes.push_back(predict_escape(px, py));
      pixels_sent++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_escapes.size() != 0);
   endtask

   task automatic check_csr(input logic [IDX_W-1:0] idx);
      logic [DATA_W-1:0] got;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {idx, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      got = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      case (idx)
         REG_IMAGE_WIDTH:
            if (got[DIM_W-1:0] !== cfg_model.image_width)
               report_mismatch("image_width readback", got[DIM_W-1:0],
                               cfg_model.image_width);
         REG_IMAGE_HEIGHT:
            if (got[DIM_W-1:0] !== cfg_model.image_height)
               report_mismatch("image_height readback", got[DIM_W-1:0],
                               cfg_model.image_height);
         REG_C_REAL:
            if (got[C_W-1:0] !== cfg_model.c_real)
               report_mismatch("c_real readback", $signed(got[C_W-1:0]), cfg_model.c_real);
         REG_C_IMAG:
            if (got[C_W-1:0] !== cfg_model.c_imag)
               report_mismatch("c_imag readback", $signed(got[C_W-1:0]), cfg_model.c_imag);
         REG_ITERATION_LIMIT:
            if (got[LIM_W-1:0] !== cfg_model.iteration_limit)
               report_mismatch("iteration_limit readback", got[LIM_W-1:0],
                               cfg_model.iteration_limit);
         default: ;
      endcase
   endtask

   task automatic write_csr(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
      drain_results();
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      case (idx)
         REG_IMAGE_WIDTH:     cfg_model.image_width = value[DIM_W-1:0];
         REG_IMAGE_HEIGHT:    cfg_model.image_height = value[DIM_W-1:0];
         REG_C_REAL:          cfg_model.c_real = value[C_W-1:0];
         REG_C_IMAG:          cfg_model.c_imag = value[C_W-1:0];
         REG_ITERATION_LIMIT: cfg_model.iteration_limit = value[LIM_W-1:0];
         default: ;
      endcase
      csr_writes++;
      check_csr(idx);
   endtask

   task automatic set_size(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
      write_csr(REG_IMAGE_WIDTH, DATA_W'(w));
      write_csr(REG_IMAGE_HEIGHT, DATA_W'(h));
   endtask

   task automatic set_constant(input logic signed [C_W-1:0] cr,
                               input logic signed [C_W-1:0] ci);
      write_csr(REG_C_REAL, {cr[C_W-1], cr});
      write_csr(REG_C_IMAG, {ci[C_W-1], ci});
   endtask

   task automatic set_limit(input logic [LIM_W-1:0] lim);
      write_csr(REG_ITERATION_LIMIT, DATA_W'(lim));
   endtask

   function automatic logic [DIM_W-1:0] draw_dim();
      case ($urandom_range(0, 9))
         0: return DIM_W'($urandom_range(0, 2**DIM_W - 1));
         1: return DIM_W'($urandom_range(0, 3));
         2: return DIM_W'($urandom_range(2000, MAX_DIM));
         default: return DIM_W'($urandom_range(2, 600));
      endcase
   endfunction

   function automatic logic signed [C_W-1:0] draw_constant();
      int v;
      case ($urandom_range(0, 9))
         0: v = $urandom;
         1, 2: v = int'($urandom_range(0, 2**30)) - 2**29;
         default: v = int'($urandom_range(0, 2**29)) - 2**28;
      endcase
      return v[C_W-1:0];
   endfunction

   function automatic logic [LIM_W-1:0] draw_limit();
      case ($urandom_range(0, 19))
         0: return LIM_W'($urandom_range(0, 2));
         1, 2, 3, 4, 5: return LIM_W'($urandom_range(49, 300));
         default: return LIM_W'($urandom_range(1, 48));
      endcase
   endfunction

   function automatic logic [PIX_W-1:0] draw_pixel(input logic [DIM_W-1:0] dim);
      int unsigned top;
      if (dim == 0 || $urandom_range(0, 6) == 0)
         return PIX_W'($urandom_range(0, 2**PIX_W - 1));
      top = (int'(dim) > MAX_DIM) ? MAX_DIM : int'(dim);
      return PIX_W'($urandom_range(0, top - 1));
   endfunction

   task automatic test_reset_values();
      check_csr(REG_IMAGE_WIDTH);
      check_csr(REG_IMAGE_HEIGHT);
      check_csr(REG_C_REAL);
      check_csr(REG_C_IMAG);
      check_csr(REG_ITERATION_LIMIT);
      send_pixel(512, 512);
      send_pixel(0, 0);
      send_pixel(4095, 4095);
      send_pixel(768, 512);
      send_pixel(4095, 0);
      send_pixel(0, 4095);
   endtask

   task automatic test_constant_extremes();
      set_constant(C_W'(-(2**30)), C_W'(2**30 - 1));
      send_pixel(512, 512);
      set_constant(C_W'(2**30 - 1), C_W'(-(2**30)));
      send_pixel(0, 0);
      set_constant(C_W'(2**26), 0);
      send_pixel(512, 512);
   endtask

   task automatic test_limit_extremes();
      set_constant(0, 0);
      set_limit(0);
      send_pixel(512, 512);
      send_pixel(0, 0);
      set_limit(1);
      send_pixel(512, 512);
      send_pixel(0, 0);
      set_limit(LIM_W'(2**LIM_W - 1));
      send_pixel(512, 512);
      set_constant(C_W'(69793218), 0);
      send_pixel(512, 512);
   endtask

   task automatic test_size_cases();
      set_limit(64);
      set_size(DIM_W'(2**DIM_W - 1), DIM_W'(MAX_DIM + 1));
      send_pixel(2048, 2048);
      send_pixel(4095, 0);
      set_size(1, 0);
      send_pixel(0, 0);
      send_pixel(1, 0);
      send_pixel(4095, 4095);
      set_size(0, 0);
      send_pixel(0, 1);
      set_size(2, 3);
      send_pixel(0, 0);
      send_pixel(1, 2);
   endtask

   // receiver holds off long enough that the block backs up onto its input
   task automatic test_output_holdoff();
      set_size(64, 64);
      set_constant(0, 0);
      set_limit(3);
      send_gaps = 1'b0;
      hold_cycles = 400;
      repeat (12) send_pixel(draw_pixel(64), draw_pixel(64));
      drain_results();
      send_gaps = 1'b1;
   endtask

   task automatic test_pause_for_drain();
      set_constant(C_W'(-(2**28) / 4 * 3), C_W'(2**28 / 10));
      set_limit(40);
      repeat (3) begin
         repeat (10) send_pixel(draw_pixel(64), draw_pixel(64));
         drain_results();
      end
   endtask

   task automatic test_random_phases();
      repeat (PHASES) begin
         set_size(draw_dim(), draw_dim());
         set_constant(draw_constant(), draw_constant());
         set_limit(draw_limit());
         send_gaps = ($urandom_range(0, 3) != 0);
         stall_gaps = ($urandom_range(0, 3) != 0);
         repeat (PHASE_PIXELS)
            send_pixel(draw_pixel(cfg_model.image_width), draw_pixel(cfg_model.image_height));
      end
      send_gaps = 1'b1;
      stall_gaps = 1'b1;
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_values();
      test_constant_extremes();
      test_limit_extremes();
      test_size_cases();
      test_output_holdoff();
      test_pause_for_drain();
      test_random_phases();
      drain_results();
      repeat (200) @(posedge clock);
      $display("%0d pixels mapped and iterated, %0d results compared", pixels_sent,
               results_checked);
      $display("%0d register writes with readback, %0d mismatches", csr_writes, mismatches);
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

[sim.f]
+incdir+rtl
rtl/jet_pkg.sv
rtl/jet_csr.sv
rtl/jet_ctrl.sv
rtl/jet_dpath.sv
rtl/julia_escape_time_pixel_top.sv
test/tb.sv
